@@ design/checksummed_packet_deframer_assert.svh @@
// assertion macros shared by the deframer modules
`ifndef CHECKSUMMED_PACKET_DEFRAMER_ASSERT_SVH
`define CHECKSUMMED_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CPD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/cpd_pkg.sv @@
// shared constants, command/status types and checksum function of the deframer
`default_nettype none

package cpd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam logic [7:0] HEADER_RESET = 8'hCC;
   localparam int CNT_W = 6;   // width of payload_count, fits any buffer depth up to 63

   typedef struct packed {
      logic take_len;   // length byte transfer
      logic take_id;    // id byte transfer
      logic take_pay;   // payload byte transfer
      logic clr_cnt;    // byte seen while hunting for the header
      logic clr_sum;    // checksum byte transfer
      logic emit_hdr;   // load header result into the output register
      logic rd_en;      // read payload buffer at the drain index
      logic emit_pay;   // load payload result into the output register
   } cpd_cmd_type;

   typedef struct packed {
      logic hdr_match;  // incoming byte equals header_value
      logic pay_more;   // packet still has payload bytes to come
      logic sum_ok;     // checksum matches and payload fit the buffer
      logic cnt_zero;   // packet has no payload
      logic last_pay;   // drain index is at the final payload byte
      logic out_free;   // output register can take a new result
   } cpd_stat_type;

   // rotate right by one, then add modulo 256
   function automatic logic [7:0] bsd_add(input logic [7:0] sum, input logic [7:0] b);
      logic [7:0] rot;
      rot = {sum[0], sum[7:1]};
      return rot + b;
   endfunction

endpackage

`default_nettype wire

@@ design/cpd_datapath.sv @@
// deframer datapath: header register, checksum, counters, payload buffer, output register
`default_nettype none

module cpd_datapath
   import cpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic [7:0]        rx_byte,
   input  wire cpd_cmd_type       cmd,
   output cpd_stat_type           stat,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_packet_id,
   output logic [CNT_W-1:0]       rsp_payload_count,
   output logic [7:0]             rsp_data,
   output logic [4:0]             rsp_byte_index,
   output logic                   rsp_last
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

   logic [7:0]       hdr_val_ff, hdr_val_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff;
   logic [7:0]       rsp_id_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [7:0]       rsp_data_ff;
   logic [4:0]       rsp_index_ff;
   logic             rsp_last_ff;
   logic [7:0]       payload_mem_ff [MAX_PAYLOAD];
   logic [7:0]       rd_data_ff;
   logic             out_free;
   logic             last_pay;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_pay = (8'(rd_idx_ff) + 8'd1) == cnt_ff;

   always_comb begin
      stat.hdr_match = (rx_byte == hdr_val_ff);
      stat.pay_more  = (len_ff != 8'd0) && (cnt_ff < (len_ff - 8'd1));
      stat.sum_ok    = (rx_byte == sum_ff) && (cnt_ff <= MAX_B);
      stat.cnt_zero  = (cnt_ff == 8'd0);
      stat.last_pay  = last_pay;
      stat.out_free  = out_free;
   end

   always_comb begin
      hdr_val_in = csr_wr_en ? csr_wr_data : hdr_val_ff;
      len_in     = cmd.take_len ? rx_byte : len_ff;
      id_in      = cmd.take_id ? rx_byte : id_ff;
      sum_in     = sum_ff;
      if (cmd.take_id || cmd.take_pay) begin
         sum_in = bsd_add(sum_ff, rx_byte);
      end else if (cmd.clr_sum) begin
         sum_in = 8'd0;
      end
      cnt_in = cnt_ff;
      if (cmd.clr_cnt) begin
         cnt_in = 8'd0;
      end else if (cmd.take_pay) begin
         cnt_in = cnt_ff + 8'd1;
      end
      rd_idx_in = rd_idx_ff;
      if (cmd.emit_hdr) begin
         rd_idx_in = '0;
      end else if (cmd.emit_pay) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_hdr || cmd.emit_pay) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_val_ff   <= HEADER_RESET;
         sum_ff       <= 8'd0;
         len_ff       <= 8'd0;
         id_ff        <= 8'd0;
         cnt_ff       <= 8'd0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_val_ff   <= hdr_val_in;
         sum_ff       <= sum_in;
         len_ff       <= len_in;
         id_ff        <= id_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (cmd.emit_hdr) begin
         rsp_kind_ff  <= 1'b0;
         rsp_id_ff    <= id_ff;
         rsp_count_ff <= cnt_ff[CNT_W-1:0];
         rsp_data_ff  <= 8'd0;
         rsp_index_ff <= 5'd0;
         rsp_last_ff  <= (cnt_ff == 8'd0);
      end else if (cmd.emit_pay) begin
         rsp_kind_ff  <= 1'b1;
         rsp_id_ff    <= id_ff;
         rsp_count_ff <= cnt_ff[CNT_W-1:0];
         rsp_data_ff  <= rd_data_ff;
         rsp_index_ff <= rd_idx_ff[4:0];
         rsp_last_ff  <= last_pay;
      end
   end

   // payload buffer, bytes past the end are counted but not kept
   always_ff @(posedge clock) begin
      if (cmd.take_pay && (cnt_ff < MAX_B)) begin
         payload_mem_ff[cnt_ff[AW-1:0]] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= payload_mem_ff[rd_idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_packet_id     = rsp_id_ff;
   assign rsp_payload_count = rsp_count_ff;
   assign rsp_data          = rsp_data_ff;
   assign rsp_byte_index    = rsp_index_ff;
   assign rsp_last          = rsp_last_ff;

`include "checksummed_packet_deframer_assert.svh"

   `CPD_ASSERT_IMPL(a_load_when_free, cmd.emit_hdr || cmd.emit_pay, out_free, "result overwritten")
   `CPD_ASSERT_IMPL(a_hdr_fits, cmd.emit_hdr, cnt_ff <= MAX_B, "oversized packet emitted")

endmodule

`default_nettype wire

@@ design/cpd_ctrl.sv @@
// deframer controller: packet parse and result drain sequencing
`default_nettype none

module cpd_ctrl
   import cpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire cpd_stat_type stat,
   output cpd_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_LEN,
      ST_ID,
      ST_PAY,
      ST_SUM,
      ST_HDR,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;
   logic      in_accept;

   assign in_accept = req_valid && !req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_WAIT: begin
            if (in_accept) begin
               cmd.clr_cnt = 1'b1;
               if (stat.hdr_match) begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (in_accept) begin
               cmd.take_len = 1'b1;
               state_in     = ST_ID;
            end
         end
         ST_ID: begin
            if (in_accept) begin
               cmd.take_id = 1'b1;
               state_in    = ST_PAY;
            end
         end
         ST_PAY: begin
            if (in_accept) begin
               if (stat.pay_more) begin
                  cmd.take_pay = 1'b1;
               end else begin
                  state_in = ST_SUM;   // trailer byte, no check
               end
            end
         end
         ST_SUM: begin
            if (in_accept) begin
               cmd.clr_sum = 1'b1;
               state_in    = stat.sum_ok ? ST_HDR : ST_WAIT;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               cmd.emit_hdr = 1'b1;
               state_in     = stat.cnt_zero ? ST_WAIT : ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.emit_pay = 1'b1;
               state_in     = stat.last_pay ? ST_WAIT : ST_READ;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
      req_stall_in = (state_in == ST_HDR) || (state_in == ST_READ) || (state_in == ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

`include "checksummed_packet_deframer_assert.svh"

   `CPD_ASSERT_IMPL(a_drain_stalls, cmd.rd_en || cmd.emit_hdr || cmd.emit_pay, req_stall_ff, "transfer during drain")
   `CPD_ASSERT_NEXT(a_drain_ends, cmd.emit_pay && stat.last_pay, !req_stall_ff, "input not reopened after drain")

endmodule

`default_nettype wire

@@ design/checksummed_packet_deframer.sv @@
// Checksummed packet deframer. Received bytes arrive one per req_ transfer; a packet is a header
// byte equal to the csr_ register (reset 0xCC), a length byte LEN, an ID byte, max(LEN-1,0)
// payload bytes, a trailer byte that is not checked and a checksum byte. A BSD rotate-right-
// and-add checksum runs over the ID and payload. On a match the block delivers a header result
// (kind 0) and then one result per payload byte (kind 1), the final one marked with last; on a
// mismatch, or a payload longer than MAX_PAYLOAD, the packet is dropped without any result.
// After an accepted checksum byte that matches, req_stall stays high while the packet drains: the
// header result is loaded into the output register, then each payload byte is read from the
// payload buffer into a read register and then loaded into the output register; any rsp_stall time
// lengthens the drain. The last result waits in the output register while new bytes are taken.
`default_nettype none

module checksummed_packet_deframer
   import cpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_packet_id,
   output logic [CNT_W-1:0]      rsp_payload_count,
   output logic [7:0]            rsp_data,
   output logic [4:0]            rsp_byte_index,
   output logic                  rsp_last
);

   cpd_cmd_type  cmd;
   cpd_stat_type stat;

   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rx_byte           (req_rx_byte),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_packet_id     (rsp_packet_id),
      .rsp_payload_count (rsp_payload_count),
      .rsp_data          (rsp_data),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

@@ dv/tb_checksummed_packet_deframer.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the checksummed packet deframer with random idling on both sides
module tb_checksummed_packet_deframer;
   import cpd_pkg::*;

   localparam int MAX_PAY = MAX_PAYLOAD_DEFAULT;
   localparam int PAY_AW = (MAX_PAY > 1) ? $clog2(MAX_PAY) : 1;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      DF_HUNT,
      DF_LENGTH,
      DF_ID,
      DF_PAYLOAD,
      DF_CHECK
   } deframe_phase_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       packet_id;
      logic [CNT_W-1:0] payload_count;
      logic [7:0]       data;
      logic [4:0]       byte_index;
      logic             last;
   } frame_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [7:0]       csr_wr_data = 8'h00;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_kind;
   logic [7:0]       rsp_packet_id;
   logic [CNT_W-1:0] rsp_payload_count;
   logic [7:0]       rsp_data;
   logic [4:0]       rsp_byte_index;
   logic             rsp_last;

   // deframer state as this testbench sees it
   deframe_phase_type df_phase = DF_HUNT;
   logic [7:0]       hdr_value = HEADER_RESET;
   logic [7:0]       run_sum = 8'h00;
   logic [7:0]       len_byte = 8'h00;
   logic [7:0]       id_byte = 8'h00;
   logic [7:0]       pay_cnt = 8'h00;
   logic [7:0]       pay_buf [MAX_PAY];

   logic [7:0]       rx_backlog [$];
   frame_result_type frames_due [$];
   frame_result_type got_frame;
   frame_result_type want_frame;

   bit               quiet = 1'b0;
   bit               req_took = 1'b0;
   bit               acc_req;
   bit               acc_rsp;
   int               gap_left = 0;
   int               stall_left = 0;
   int               idle_cycles = 0;
   int               mismatches = 0;
   int               packet_bytes = 0;
   int               bytes_in = 0;
   int               results_seen = 0;
   int               packets_seen = 0;
   int               header_writes = 0;

   checksummed_packet_deframer #(
      .MAX_PAYLOAD(MAX_PAY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_packet_id(rsp_packet_id),
      .rsp_payload_count(rsp_payload_count),
      .rsp_data(rsp_data),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // rotate right by one, then add
   function automatic logic [7:0] rot_add(input logic [7:0] sum, input logic [7:0] b);
      return {sum[0], sum[7:1]} + b;
   endfunction

   function void deframe_byte(input logic [7:0] b);
      frame_result_type r;
      int            i;
      case (df_phase)
         DF_HUNT: begin
            pay_cnt = 8'h00;
            if (b == hdr_value) df_phase = DF_LENGTH;
         end
         DF_LENGTH: begin
            len_byte = b;
            df_phase = DF_ID;
         end
         DF_ID: begin
            id_byte = b;
            run_sum = rot_add(run_sum, b);
            df_phase = DF_PAYLOAD;
         end
         DF_PAYLOAD: begin
            if (len_byte != 8'h00 && pay_cnt < len_byte - 8'd1) begin
               // bytes past the buffer still count and feed the sum
               if (pay_cnt < MAX_PAY) pay_buf[pay_cnt[PAY_AW-1:0]] = b;
               run_sum = rot_add(run_sum, b);
               pay_cnt = pay_cnt + 8'd1;
            end else begin
               df_phase = DF_CHECK;
            end
         end
         DF_CHECK: begin
            if (b == run_sum && pay_cnt <= MAX_PAY) begin
               r.kind = KIND_HEADER;
               r.packet_id = id_byte;
               r.payload_count = pay_cnt[CNT_W-1:0];
               r.data = 8'h00;
               r.byte_index = 5'd0;
               r.last = (pay_cnt == 8'h00);
               frames_due.push_back(r);
               for (i = 0; i < pay_cnt; i++) begin
                  r.kind = KIND_PAYLOAD;
                  r.data = pay_buf[i[PAY_AW-1:0]];
                  r.byte_index = i[4:0];
                  r.last = (i + 1 == pay_cnt);
                  frames_due.push_back(r);
               end
            end
            run_sum = 8'h00;
            pay_cnt = 8'h00;
            df_phase = DF_HUNT;
         end
         default: df_phase = DF_HUNT;
      endcase
   endfunction

   function string show_frame(input frame_result_type f);
      return $sformatf("kind=%0d id=%02h count=%0d data=%02h index=%0d last=%0d",
                       f.kind, f.packet_id, f.payload_count, f.data, f.byte_index, f.last);
   endfunction

   function void note_failure(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   // sender: one byte per transfer, random gaps between transfers
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_backlog.pop_front();
         end
      end
   end

   // receiver: random stall bursts
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         acc_req = req_valid && !req_stall;
         acc_rsp = rsp_valid && !rsp_stall;
         // check before predicting, a result can never stem from this same transfer
         if (acc_rsp) begin
            got_frame.kind = rsp_kind;
            got_frame.packet_id = rsp_packet_id;
            got_frame.payload_count = rsp_payload_count;
            got_frame.data = rsp_data;
            got_frame.byte_index = rsp_byte_index;
            got_frame.last = rsp_last;
            results_seen++;
            if (rsp_kind == KIND_HEADER) packets_seen++;
            if (frames_due.size() == 0) begin
               note_failure({"result with nothing expected: ", show_frame(got_frame)});
            end else begin
               want_frame = frames_due.pop_front();
               if (got_frame.kind !== want_frame.kind ||
                   got_frame.packet_id !== want_frame.packet_id ||
                   got_frame.payload_count !== want_frame.payload_count ||
                   got_frame.data !== want_frame.data ||
                   got_frame.byte_index !== want_frame.byte_index ||
                   got_frame.last !== want_frame.last)
                  note_failure({"mismatch: expected ", show_frame(want_frame),
                                " got ", show_frame(got_frame)});
            end
         end
         if (acc_req) begin
            deframe_byte(req_rx_byte);
            bytes_in++;
            req_took = 1'b1;
         end
         if (acc_req || acc_rsp) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still due",
                     $time, idle_cycles, frames_due.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function void push_byte(input logic [7:0] b);
      rx_backlog.push_back(b);
      packet_bytes++;
   endfunction

   // fill < 0 gives random payload, otherwise every payload byte is fill
   task automatic add_packet(input int len, input logic [7:0] id, input bit good,
                             input int fill);
      logic [7:0] sum;
      logic [7:0] b;
      int         n;
      n = (len > 0) ? len - 1 : 0;
      sum = rot_add(8'h00, id);
      push_byte(hdr_value);
      push_byte(8'(len));
      push_byte(id);
      repeat (n) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         sum = rot_add(sum, b);
         push_byte(b);
      end
      push_byte(8'($urandom));
      push_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic random_phase(input int quota);
      int first;
      int len;
      int roll;
      first = packet_bytes;
      while (packet_bytes - first < quota) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) rx_backlog.push_back(8'($urandom));
         roll = $urandom_range(0, 99);
         if (roll < 65) len = $urandom_range(0, 6);
         else if (roll < 88) len = $urandom_range(7, 31);
         else len = $urandom_range(32, 34);
         if ($urandom_range(0, 11) == 0) begin
            // cut-off packet, whatever follows is swallowed as its body
            push_byte(hdr_value);
            push_byte(8'(len + 3));
            push_byte(8'($urandom));
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
         end else begin
            add_packet(len, 8'($urandom), $urandom_range(0, 6) != 0,
                       ($urandom_range(0, 9) == 0) ? int'(hdr_value) : -1);
         end
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (rx_backlog.size() != 0 || req_valid || frames_due.size() != 0);
   endtask

   // only called once drained; a dropped packet leaves nothing in flight by the time of the write
   task automatic write_header(input logic [7:0] value);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      #1;
      hdr_value = value;
      header_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      // directed packets under the reset header value
      rx_backlog.push_back(8'h00);
      add_packet(0, 8'h00, 1'b1, -1);
      add_packet(1, 8'hFF, 1'b1, -1);
      add_packet(2, 8'h5A, 1'b1, 8'hFF);
      add_packet(3, 8'h01, 1'b1, int'(hdr_value));
      add_packet(2, 8'h33, 1'b0, 8'h00);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_drained();

      write_header(8'h00);
      add_packet(MAX_PAY + 1, 8'hA5, 1'b1, -1);
      add_packet(MAX_PAY + 2, 8'h3C, 1'b1, -1);
      wait_drained();
      random_phase(20);
      wait_drained();

      write_header(8'hFF);
      random_phase(20);
      wait_drained();

      write_header(8'($urandom_range(1, 254)));
      add_packet($urandom_range(35, 80), 8'($urandom), 1'b1, -1);
      random_phase(20);
      wait_drained();

      quiet = 1'b1;
      write_header(HEADER_RESET);
      random_phase(20);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d received bytes and %0d header settings, including 00 and ff",
               bytes_in, header_writes);
      $display("%0d packets delivered as %0d results, %0d failures", packets_seen,
               results_seen, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/cpd_pkg.sv
design/cpd_datapath.sv
design/cpd_ctrl.sv
design/checksummed_packet_deframer.sv
dv/tb_checksummed_packet_deframer.sv
